@@ sv/sorted_word_table_lookup_defines.svh @@
// Assertion macros shared by the word table lookup block.
`ifndef SORTED_WORD_TABLE_LOOKUP_DEFINES_SVH
`define SORTED_WORD_TABLE_LOOKUP_DEFINES_SVH

// The condition must never hold outside reset.
`define SWTL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SWTL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/swtl_pkg.sv @@
`default_nettype none

package swtl_pkg;

  localparam int TABLE_DEPTH  = 512;
  localparam int WORD_BYTES   = 8;

  localparam int FUNC_W       = 1;
  localparam int IDX_W        = 9;
  localparam int CHARS_W      = 64;
  localparam int CODE_W       = 14;
  localparam int CLASS_W      = 4;
  localparam int CNT_W        = 10;
  localparam int CLASS_DIV    = 1000;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 1'b1;

  // Keeps the characters up to the first zero byte, within the first nbytes.
  function automatic logic [CHARS_W-1:0] norm_word(input logic [CHARS_W-1:0] w,
                                                   input int nbytes);
    logic [CHARS_W-1:0] r;
    logic               stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < CHARS_W / 8; i++) begin
      if (i >= nbytes || w[CHARS_W-1-8*i -: 8] == 8'h00) stop = 1'b1;
      if (!stop) r[CHARS_W-1-8*i -: 8] = w[CHARS_W-1-8*i -: 8];
    end
    return r;
  endfunction

  // Lowest code of a class: a code is at or above class c when code >= c * 1000.
  function automatic logic [CODE_W-1:0] class_floor(input logic [CLASS_W-1:0] c);
    return CODE_W'(32'(c) * 32'(CLASS_DIV));
  endfunction

endpackage

`default_nettype wire

@@ sv/swtl_channel_if.sv @@
`default_nettype none

interface swtl_in_if;
  logic                            valid;
  logic                            ready;
  logic [swtl_pkg::FUNC_W-1:0]     func;
  logic [swtl_pkg::IDX_W-1:0]      entry_index;
  logic [swtl_pkg::CHARS_W-1:0]    word_chars;
  logic [swtl_pkg::CODE_W-1:0]     entry_code;
  logic [swtl_pkg::CLASS_W-1:0]    min_class;

  modport source (output valid, func, entry_index, word_chars, entry_code, min_class,
                  input ready);
  modport sink   (input valid, func, entry_index, word_chars, entry_code, min_class,
                  output ready);
endinterface

interface swtl_out_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [swtl_pkg::CODE_W-1:0]     result_code;

  modport source (output valid, found, result_code, input ready);
  modport sink   (input valid, found, result_code, output ready);
endinterface

`default_nettype wire

@@ sv/swtl_ram.sv @@
`default_nettype none

module swtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/swtl_seq.sv @@
`default_nettype none

module swtl_seq #(
  parameter int TABLE_DEPTH = swtl_pkg::TABLE_DEPTH,
  parameter int WORD_BYTES  = swtl_pkg::WORD_BYTES
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst_n,
  input  wire logic [swtl_pkg::CNT_W-1:0]                         entries_used,
  swtl_in_if.sink                                                 in_ch,
  swtl_out_if.source                                              out_ch,
  output      logic                                               ram_wr_en,
  output      logic [$clog2(TABLE_DEPTH)-1:0]                     ram_wr_addr,
  output      logic [8*WORD_BYTES+swtl_pkg::CODE_W-1:0]           ram_wr_data,
  output      logic [$clog2(TABLE_DEPTH)-1:0]                     ram_rd_addr,
  input  wire logic [8*WORD_BYTES+swtl_pkg::CODE_W-1:0]           ram_rd_data
);

  localparam int IW     = $clog2(TABLE_DEPTH);
  localparam int WW     = 8 * WORD_BYTES;
  localparam int CODE_W = swtl_pkg::CODE_W;
  localparam int DW     = WW + CODE_W;
  localparam logic [IW:0] ONE_EXT = (IW + 1)'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_NBR_LO,
    S_NBR_HI,
    S_SELECT,
    S_OUT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [WW-1:0]                  word_r, word_nxt;
  logic [swtl_pkg::CLASS_W-1:0]   minc_r, minc_nxt;
  logic [IW-1:0]                  lo_r, lo_nxt;
  logic [IW-1:0]                  hi_r, hi_nxt;
  logic [IW-1:0]                  mid_r, mid_nxt;
  logic [IW-1:0]                  last_r, last_nxt;
  logic [IW-1:0]                  v1_r, v1_nxt;
  logic [CODE_W-1:0]              c1_r, c1_nxt;
  logic [CODE_W-1:0]              c2_r, c2_nxt;
  logic                           found_r, found_nxt;
  logic [CODE_W-1:0]              code_r, code_nxt;

  logic                           accept;
  logic [swtl_pkg::CHARS_W-1:0]   in_norm;
  logic [WW-1:0]                  in_word;
  logic                           cnt_clamp;
  logic                           tbl_empty;
  logic [IW-1:0]                  last_in;
  logic [WW-1:0]                  rd_word;
  logic [CODE_W-1:0]              rd_code;
  logic                           w_eq;
  logic                           w_lt;
  logic [IW-1:0]                  cand_l;
  logic [IW-1:0]                  cand_r;
  logic [CODE_W-1:0]              sel_lo;
  logic [CODE_W-1:0]              sel_hi;
  logic [CODE_W-1:0]              floor_code;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_norm  = swtl_pkg::norm_word(in_ch.word_chars, WORD_BYTES);
  assign in_word  = in_norm[swtl_pkg::CHARS_W-1 -: WW];

  // Searched count is entries_used, clamped to the table depth.
  assign cnt_clamp = 32'(entries_used) > 32'(TABLE_DEPTH);
  assign tbl_empty = entries_used == '0;
  assign last_in   = cnt_clamp ? IW'(TABLE_DEPTH - 1) : IW'(32'(entries_used) - 32'd1);

  assign ram_wr_en   = accept && in_ch.func == swtl_pkg::FUNC_LOAD &&
                       32'(in_ch.entry_index) < 32'(TABLE_DEPTH);
  assign ram_wr_addr = IW'(in_ch.entry_index);
  assign ram_wr_data = {in_word, in_ch.entry_code};

  assign rd_word = ram_rd_data[DW-1 -: WW];
  assign rd_code = ram_rd_data[CODE_W-1:0];

  // One shared comparator serves the probes and both neighbor checks.
  assign w_eq = word_r == rd_word;
  assign w_lt = word_r < rd_word;

  // Next midpoints for either outcome, prepared in parallel with the compare.
  assign cand_l = IW'(({1'b0, lo_r} + {1'b0, mid_r} - ONE_EXT) >> 1);
  assign cand_r = IW'(({1'b0, mid_r} + ONE_EXT + {1'b0, hi_r}) >> 1);

  assign sel_lo     = (c1_r > c2_r) ? c2_r : c1_r;
  assign sel_hi     = (c1_r > c2_r) ? c1_r : c2_r;
  assign floor_code = swtl_pkg::class_floor(minc_r);

  assign in_ch.ready        = state_r == S_IDLE;
  assign out_ch.valid       = state_r == S_OUT;
  assign out_ch.found       = found_r;
  assign out_ch.result_code = code_r;

  always_comb begin
    state_nxt   = state_r;
    word_nxt    = word_r;
    minc_nxt    = minc_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    last_nxt    = last_r;
    v1_nxt      = v1_r;
    c1_nxt      = c1_r;
    c2_nxt      = c2_r;
    found_nxt   = found_r;
    code_nxt    = code_r;
    ram_rd_addr = mid_r;

    case (state_r)
      S_IDLE: begin
        ram_rd_addr = last_in >> 1;
        if (accept) begin
          if (in_ch.func == swtl_pkg::FUNC_LOAD) begin
            found_nxt = 1'b1;
            code_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            word_nxt = in_word;
            minc_nxt = in_ch.min_class;
            last_nxt = last_in;
            lo_nxt   = '0;
            hi_nxt   = last_in;
            mid_nxt  = last_in >> 1;
            if (tbl_empty) begin
              found_nxt = 1'b0;
              code_nxt  = '0;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_SEARCH;
            end
          end
        end
      end

      S_SEARCH: begin
        if (w_eq) begin
          v1_nxt = mid_r;
          c1_nxt = rd_code;
          if (mid_r != '0) begin
            ram_rd_addr = mid_r - IW'(1);
            state_nxt   = S_NBR_LO;
          end else if (mid_r != last_r) begin
            ram_rd_addr = mid_r + IW'(1);
            state_nxt   = S_NBR_HI;
          end else begin
            c2_nxt    = rd_code;
            state_nxt = S_SELECT;
          end
        end else if (w_lt) begin
          if (mid_r == lo_r) begin
            found_nxt = 1'b0;
            code_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            hi_nxt      = mid_r - IW'(1);
            mid_nxt     = cand_l;
            ram_rd_addr = cand_l;
          end
        end else begin
          if (mid_r == hi_r) begin
            found_nxt = 1'b0;
            code_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            lo_nxt      = mid_r + IW'(1);
            mid_nxt     = cand_r;
            ram_rd_addr = cand_r;
          end
        end
      end

      S_NBR_LO: begin
        if (w_eq) begin
          c2_nxt    = rd_code;
          state_nxt = S_SELECT;
        end else if (v1_r != last_r) begin
          ram_rd_addr = v1_r + IW'(1);
          state_nxt   = S_NBR_HI;
        end else begin
          c2_nxt    = c1_r;
          state_nxt = S_SELECT;
        end
      end

      S_NBR_HI: begin
        c2_nxt    = w_eq ? rd_code : c1_r;
        state_nxt = S_SELECT;
      end

      S_SELECT: begin
        if (sel_lo >= floor_code) begin
          found_nxt = 1'b1;
          code_nxt  = sel_lo;
        end else if (sel_hi >= floor_code) begin
          found_nxt = 1'b1;
          code_nxt  = sel_hi;
        end else begin
          found_nxt = 1'b0;
          code_nxt  = '0;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    word_r  <= word_nxt;
    minc_r  <= minc_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    last_r  <= last_nxt;
    v1_r    <= v1_nxt;
    c1_r    <= c1_nxt;
    c2_r    <= c2_nxt;
    found_r <= found_nxt;
    code_r  <= code_nxt;
  end

endmodule

`default_nettype wire

@@ sv/sorted_word_table_lookup.sv @@
// Channel   Direction  Fields
// in_ch     input      func, entry_index, word_chars, entry_code, min_class
// out_ch    output     found, result_code
// cfg_      input      entries_used (write enable and data)
//
// On a load the table write happens on the accepting edge, and the acknowledgement
// (found set, code zero) leaves the output register in the next cycle. A lookup
// makes table probes (up to ten at 512 entries), up to two neighbor reads and one
// select step in turn, as the table has a single read port.
// Reset is synchronous and active low; the table contents are not cleared.
// in_ch.ready stays low from acceptance until out_ch hands over the result.
`default_nettype none

`include "sorted_word_table_lookup_defines.svh"

module sorted_word_table_lookup #(
  parameter int TABLE_DEPTH = swtl_pkg::TABLE_DEPTH,
  parameter int WORD_BYTES  = swtl_pkg::WORD_BYTES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [swtl_pkg::CNT_W-1:0]  cfg_wr_data,
  swtl_in_if.sink                          in_ch,
  swtl_out_if.source                       out_ch
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int DW = 8 * WORD_BYTES + swtl_pkg::CODE_W;

  logic [swtl_pkg::CNT_W-1:0] entries_used_r;
  logic                       ram_wr_en;
  logic [IW-1:0]              ram_wr_addr;
  logic [DW-1:0]              ram_wr_data;
  logic [IW-1:0]              ram_rd_addr;
  logic [DW-1:0]              ram_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_used_r <= '0;
    end else if (cfg_wr_en) begin
      entries_used_r <= cfg_wr_data;
    end
  end

  // Each entry holds the packed word above its code.
  swtl_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  swtl_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORD_BYTES  (WORD_BYTES)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .entries_used (entries_used_r),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data)
  );

  `SWTL_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ch.ready && out_ch.valid, "input taken while a result is pending")
  `SWTL_ASSERT_NEXT(a_load_ack, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.func == swtl_pkg::FUNC_LOAD, out_ch.valid && out_ch.found && out_ch.result_code == '0, "load not acknowledged in the next cycle")
  `SWTL_ASSERT_IMPL(a_miss_zero, clk, rst_n, out_ch.valid && !out_ch.found, out_ch.result_code == '0, "miss carries a nonzero code")

endmodule

`default_nettype wire
